### rtl/lsac_pkg.sv
// Shared constants, types and helper functions for the load/store ALU core.
// Used by every module under rtl except lsac_ram; depends on nothing else.
package lsac_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WORDS = 256;
    localparam int WORD_BITS  = 32;

    localparam int RA_W = $clog2(NUM_REGS);
    localparam int MA_W = $clog2(DATA_WORDS);

    localparam int OUT_IDX_W  = 4;
    localparam int OUT_ADDR_W = 8;
    localparam int OUT_VAL_W  = 32;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_LOAD  = 8'd8;
    localparam logic [7:0] OP_STORE = 8'd9;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADOP   = 2'd1,
        ST_BADREG  = 2'd2,
        ST_BADADDR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_NONE,
        K_PRELOAD,
        K_ADD,
        K_SUB,
        K_LOAD,
        K_STORE
    } t_kind;

    // Execute stage contents: decoded item plus operand bypass information.
    typedef struct packed {
        t_kind                kind;
        t_status              status;
        logic [RA_W-1:0]      dst;
        logic [MA_W-1:0]      maddr;
        logic [WORD_BITS-1:0] pre_val;
        logic                 va;
        logic                 vb;
        logic                 vm;
        logic                 fa;
        logic                 fb;
        logic                 fm;
        logic [WORD_BITS-1:0] fva;
        logic [WORD_BITS-1:0] fvb;
        logic [WORD_BITS-1:0] fvm;
    } t_s1;

    typedef struct packed {
        logic [RA_W-1:0] a;
        logic [RA_W-1:0] b;
        logic [MA_W-1:0] m;
    } t_rd;

    typedef struct packed {
        logic                 reg_we;
        logic [RA_W-1:0]      reg_idx;
        logic [WORD_BITS-1:0] reg_val;
        logic                 mem_we;
        logic [MA_W-1:0]      mem_addr;
        logic [WORD_BITS-1:0] mem_val;
    } t_commit;

    function automatic logic reg_ok(input logic [7:0] f);
        return 32'(f) < 32'(NUM_REGS);
    endfunction

    function automatic logic addr_ok(input logic [15:0] a);
        return 32'(a) < 32'(DATA_WORDS);
    endfunction

endpackage

### rtl/lsac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module lsac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lsac_decode.sv
// Instruction decode, range checks and write-to-read bypass for a new beat.
// Depends on lsac_pkg.
module lsac_decode (
    input  logic                           i_action,
    input  logic [31:0]                    i_instruction,
    input  logic [15:0]                    i_preload_address,
    input  logic [31:0]                    i_preload_value,
    input  logic [lsac_pkg::NUM_REGS-1:0]  i_reg_vld,
    input  logic [lsac_pkg::DATA_WORDS-1:0] i_mem_vld,
    input  lsac_pkg::t_commit              i_commit,
    output lsac_pkg::t_rd                  o_rd,
    output lsac_pkg::t_s1                  o_s1
);

    logic [7:0]  w_op;
    logic [7:0]  w_fd;
    logic [7:0]  w_fa;
    logic [7:0]  w_fb;
    logic [15:0] w_addr;
    lsac_pkg::t_rd w_rd;
    lsac_pkg::t_s1 w_s1;

    assign w_op   = i_instruction[7:0];
    assign w_fb   = i_instruction[15:8];
    assign w_fa   = i_instruction[23:16];
    assign w_fd   = i_instruction[31:24];
    assign w_addr = i_instruction[31:16];

    always_comb begin
        w_rd.a = w_fa[lsac_pkg::RA_W-1:0];
        w_rd.b = w_fb[lsac_pkg::RA_W-1:0];
        w_rd.m = w_addr[lsac_pkg::MA_W-1:0];

        w_s1         = '0;
        w_s1.kind    = lsac_pkg::K_NONE;
        w_s1.status  = lsac_pkg::ST_OK;
        w_s1.pre_val = lsac_pkg::WORD_BITS'(i_preload_value);

        if (i_action) begin
            w_s1.kind  = lsac_pkg::K_PRELOAD;
            w_s1.maddr = i_preload_address[lsac_pkg::MA_W-1:0];
            if (!lsac_pkg::addr_ok(i_preload_address)) begin
                w_s1.status = lsac_pkg::ST_BADADDR;
            end
        end else begin
            case (w_op)
                lsac_pkg::OP_ADD, lsac_pkg::OP_SUB: begin
                    w_s1.kind = (w_op == lsac_pkg::OP_ADD) ? lsac_pkg::K_ADD
                                                           : lsac_pkg::K_SUB;
                    w_s1.dst  = w_fd[lsac_pkg::RA_W-1:0];
                    if (!lsac_pkg::reg_ok(w_fd) || !lsac_pkg::reg_ok(w_fa) ||
                        !lsac_pkg::reg_ok(w_fb)) begin
                        w_s1.status = lsac_pkg::ST_BADREG;
                    end
                end
                lsac_pkg::OP_LOAD, lsac_pkg::OP_STORE: begin
                    w_s1.kind  = (w_op == lsac_pkg::OP_LOAD) ? lsac_pkg::K_LOAD
                                                             : lsac_pkg::K_STORE;
                    w_s1.dst   = w_fb[lsac_pkg::RA_W-1:0];
                    w_s1.maddr = w_addr[lsac_pkg::MA_W-1:0];
                    if (!lsac_pkg::reg_ok(w_fb)) begin
                        w_s1.status = lsac_pkg::ST_BADREG;
                    end else if (!lsac_pkg::addr_ok(w_addr)) begin
                        w_s1.status = lsac_pkg::ST_BADADDR;
                    end
                end
                default: begin
                    w_s1.status = lsac_pkg::ST_BADOP;
                end
            endcase
        end

        w_s1.va  = i_reg_vld[w_rd.a];
        w_s1.vb  = i_reg_vld[w_rd.b];
        w_s1.vm  = i_mem_vld[w_rd.m];
        w_s1.fa  = i_commit.reg_we && (i_commit.reg_idx == w_rd.a);
        w_s1.fb  = i_commit.reg_we && (i_commit.reg_idx == w_rd.b);
        w_s1.fm  = i_commit.mem_we && (i_commit.mem_addr == w_rd.m);
        w_s1.fva = i_commit.reg_val;
        w_s1.fvb = i_commit.reg_val;
        w_s1.fvm = i_commit.mem_val;
    end

    assign o_rd = w_rd;
    assign o_s1 = w_s1;

endmodule

### rtl/lsac_alu.sv
// Execute stage: operand selection, add/subtract and write generation.
// Depends on lsac_pkg.
module lsac_alu (
    input  lsac_pkg::t_s1                   i_s1,
    input  logic [lsac_pkg::WORD_BITS-1:0]  i_rd_a,
    input  logic [lsac_pkg::WORD_BITS-1:0]  i_rd_b,
    input  logic [lsac_pkg::WORD_BITS-1:0]  i_rd_m,
    output lsac_pkg::t_commit               o_commit
);

    logic [lsac_pkg::WORD_BITS-1:0] w_opa;
    logic [lsac_pkg::WORD_BITS-1:0] w_opb;
    logic [lsac_pkg::WORD_BITS-1:0] w_opm;
    lsac_pkg::t_commit              w_c;

    always_comb begin
        w_opa = i_s1.fa ? i_s1.fva : (i_s1.va ? i_rd_a : '0);
        w_opb = i_s1.fb ? i_s1.fvb : (i_s1.vb ? i_rd_b : '0);
        w_opm = i_s1.fm ? i_s1.fvm : (i_s1.vm ? i_rd_m : '0);

        w_c = '0;
        if (i_s1.status == lsac_pkg::ST_OK) begin
            case (i_s1.kind)
                lsac_pkg::K_PRELOAD: begin
                    w_c.mem_we   = 1'b1;
                    w_c.mem_addr = i_s1.maddr;
                    w_c.mem_val  = i_s1.pre_val;
                end
                lsac_pkg::K_ADD: begin
                    w_c.reg_we  = 1'b1;
                    w_c.reg_idx = i_s1.dst;
                    w_c.reg_val = w_opa + w_opb;
                end
                lsac_pkg::K_SUB: begin
                    w_c.reg_we  = 1'b1;
                    w_c.reg_idx = i_s1.dst;
                    w_c.reg_val = w_opa - w_opb;
                end
                lsac_pkg::K_LOAD: begin
                    w_c.reg_we  = 1'b1;
                    w_c.reg_idx = i_s1.dst;
                    w_c.reg_val = w_opm;
                end
                lsac_pkg::K_STORE: begin
                    w_c.mem_we   = 1'b1;
                    w_c.mem_addr = i_s1.maddr;
                    w_c.mem_val  = w_opb;
                end
                default: begin
                    w_c = '0;
                end
            endcase
        end
    end

    assign o_commit = w_c;

endmodule

### rtl/load_store_alu_core.sv
// Top level of the load/store ALU core: handshakes, execute stage, result register.
// Depends on lsac_pkg, lsac_ram, lsac_decode and lsac_alu.
//
//   port group   dir   tdata / tuser                       beat
//   s_axis       in    instruction, address, value / action one instruction or preload
//   m_axis       out   status, register and memory writes   one result per input beat
//
// A beat is decoded and its operands read in the accept cycle; it is then executed and committed
// from the execute stage register, and its result is presented from the result register.
// One beat per cycle is sustained while m_axis takes results; the register file and data store
// commit one write per cycle and the next beat's reads are bypassed from that write.
// Synchronous active-low reset empties both stages and marks all words as zero.
// A stalled result register holds the execute stage, which then holds s_axis.
module load_store_alu_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // instruction[31:0], preload_address[47:32], preload_value[79:48]
    input  logic [lsac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], reg_written[2], reg_index[6:3], reg_value[38:7],
    // mem_written[39], mem_address[47:40], mem_value[79:48]
    output logic [lsac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                              r_s1_vld;
    lsac_pkg::t_s1                     r_s1;
    logic                              r_out_vld;
    logic [lsac_pkg::OUT_TDATA_W-1:0]  r_out;
    logic [lsac_pkg::NUM_REGS-1:0]     r_reg_vld;
    logic [lsac_pkg::DATA_WORDS-1:0]   r_mem_vld;

    logic                              w_s1_adv;
    logic                              w_accept;
    logic                              w_commit_en;
    lsac_pkg::t_commit                 w_alu;
    lsac_pkg::t_commit                 w_commit;
    lsac_pkg::t_rd                     w_rd;
    lsac_pkg::t_s1                     n_s1;
    logic [lsac_pkg::OUT_TDATA_W-1:0]  n_out;
    logic [lsac_pkg::WORD_BITS-1:0]    w_rd_a;
    logic [lsac_pkg::WORD_BITS-1:0]    w_rd_b;
    logic [lsac_pkg::WORD_BITS-1:0]    w_rd_m;

    assign w_s1_adv      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit_en   = r_s1_vld && w_s1_adv;

    lsac_alu u_alu (
        .i_s1     (r_s1),
        .i_rd_a   (w_rd_a),
        .i_rd_b   (w_rd_b),
        .i_rd_m   (w_rd_m),
        .o_commit (w_alu)
    );

    always_comb begin
        w_commit        = w_alu;
        w_commit.reg_we = w_alu.reg_we && w_commit_en;
        w_commit.mem_we = w_alu.mem_we && w_commit_en;
    end

    lsac_decode u_decode (
        .i_action          (s_axis_tuser),
        .i_instruction     (s_axis_tdata[31:0]),
        .i_preload_address (s_axis_tdata[47:32]),
        .i_preload_value   (s_axis_tdata[79:48]),
        .i_reg_vld         (r_reg_vld),
        .i_mem_vld         (r_mem_vld),
        .i_commit          (w_commit),
        .o_rd              (w_rd),
        .o_s1              (n_s1)
    );

    lsac_ram #(
        .WIDTH (lsac_pkg::WORD_BITS),
        .DEPTH (lsac_pkg::NUM_REGS)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_commit.reg_we),
        .i_waddr (w_commit.reg_idx),
        .i_wdata (w_commit.reg_val),
        .i_re    (w_accept),
        .i_raddr (w_rd.a),
        .o_rdata (w_rd_a)
    );

    lsac_ram #(
        .WIDTH (lsac_pkg::WORD_BITS),
        .DEPTH (lsac_pkg::NUM_REGS)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_commit.reg_we),
        .i_waddr (w_commit.reg_idx),
        .i_wdata (w_commit.reg_val),
        .i_re    (w_accept),
        .i_raddr (w_rd.b),
        .o_rdata (w_rd_b)
    );

    lsac_ram #(
        .WIDTH (lsac_pkg::WORD_BITS),
        .DEPTH (lsac_pkg::DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (w_commit.mem_we),
        .i_waddr (w_commit.mem_addr),
        .i_wdata (w_commit.mem_val),
        .i_re    (w_accept),
        .i_raddr (w_rd.m),
        .o_rdata (w_rd_m)
    );

    assign n_out = {lsac_pkg::OUT_VAL_W'(w_alu.mem_val),
                    lsac_pkg::OUT_ADDR_W'(w_alu.mem_addr),
                    w_alu.mem_we,
                    lsac_pkg::OUT_VAL_W'(w_alu.reg_val),
                    lsac_pkg::OUT_IDX_W'(w_alu.reg_idx),
                    w_alu.reg_we,
                    r_s1.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_reg_vld <= '0;
            r_mem_vld <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1_vld <= w_accept;
            end
            if (w_s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (w_commit.reg_we) begin
                r_reg_vld[w_commit.reg_idx] <= 1'b1;
            end
            if (w_commit.mem_we) begin
                r_mem_vld[w_commit.mem_addr] <= 1'b1;
            end
        end
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_commit_en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_no_intake_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && !m_axis_tready |-> !s_axis_tready)
        else $error("execute stage overwritten while held");

    a_write_needs_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit.reg_we || w_commit.mem_we) |-> r_s1.status == lsac_pkg::ST_OK)
        else $error("write committed for a failing beat");

    a_single_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> !(w_alu.reg_we && w_alu.mem_we))
        else $error("beat writes both register file and data store");

    a_reg_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit.reg_we |=> r_reg_vld[$past(w_commit.reg_idx)])
        else $error("written register not marked valid");

endmodule
